>>> src/tmcw_pkg.sv
// shared types and constants for the text-mode console writer
package tmcw_pkg;

  localparam int CELL_ADDR_W = 12;
  localparam int ROW_W       = 5;
  localparam int COL_W       = 7;
  localparam int IDX_W       = 11;
  localparam int CELL_W      = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  localparam logic [1:0] FUNC_PUT   = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_SET   = 2'd2;
  localparam logic [1:0] FUNC_READ  = 2'd3;

  localparam logic [7:0] CODE_NEWLINE = 8'd10;
  localparam logic [7:0] CODE_TAB     = 8'd9;
  localparam logic [7:0] CODE_SPACE   = 8'd32;

  localparam logic [7:0]        RESET_COLOR = 8'd79;
  localparam logic [CELL_W-1:0] RESET_CELL  = 16'h4F20;

  // one command for the back end, with the result it reports
  typedef struct packed {
    logic                   pre_clr;
    logic [CELL_ADDR_W-1:0] pre_base;
    logic                   do_wr;
    logic                   do_rd;
    logic [CELL_ADDR_W-1:0] addr;
    logic [CELL_W-1:0]      wdata;
    logic                   post_clr;
    logic [CELL_ADDR_W-1:0] post_base;
    logic [IDX_W-1:0]       cursor_index;
    logic [COL_W-1:0]       cursor_column;
    logic [ROW_W-1:0]       cursor_row;
    logic                   scrolled;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef struct packed {
    logic init_busy;
  } back_status_t;

endpackage

>>> src/text_mode_console_writer.sv
// top level of the text-mode console writer
// flow: an accepted item is queued and popped by the back end, which clears the bottom row
//   if the step scrolls before the cell, accesses the cell, clears the bottom row if the step
//   scrolls after, and loads the output register, held while out_stall is high; the back
//   end pops the next command only after that load. reset is synchronous; the store is
//   filled with spaces in colour 79, all SCREEN_WIDTH*SCREEN_HEIGHT cells, while in_stall is high
module text_mode_console_writer
  import tmcw_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 80,
  parameter int SCREEN_HEIGHT = 25,
  parameter int TAB_STEP      = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_func,
  input  logic [7:0]       in_character,
  input  logic [7:0]       in_entry_color,
  input  logic [COL_W-1:0] in_column,
  input  logic [ROW_W-1:0] in_row,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [IDX_W-1:0] out_cursor_index,
  output logic [COL_W-1:0] out_cursor_column,
  output logic [ROW_W-1:0] out_cursor_row,
  output logic [15:0]      out_cell_data,
  output logic             out_scrolled,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [7:0]       cfg_text_color
);

  back_status_t  back_status;
  queue_status_t q_status;
  logic          push;
  logic          pop;
  cmd_t          push_cmd;
  cmd_t          pop_cmd;

  tmcw_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .TAB_STEP      (TAB_STEP)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_character   (in_character),
    .in_entry_color (in_entry_color),
    .in_column      (in_column),
    .in_row         (in_row),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_text_color (cfg_text_color),
    .back_status    (back_status),
    .q_status       (q_status),
    .push           (push),
    .push_cmd       (push_cmd)
  );

  tmcw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .status   (q_status)
  );

  tmcw_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_status          (q_status),
    .pop               (pop),
    .pop_cmd           (pop_cmd),
    .status            (back_status),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_cursor_index  (out_cursor_index),
    .out_cursor_column (out_cursor_column),
    .out_cursor_row    (out_cursor_row),
    .out_cell_data     (out_cell_data),
    .out_scrolled      (out_scrolled)
  );

endmodule

>>> src/tmcw_queue.sv
// command queue between the front end and the back end
module tmcw_queue
  import tmcw_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  cmd_t          push_cmd,
  input  logic          pop,
  output cmd_t          pop_cmd,
  output queue_status_t status
);

  cmd_t              q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;

  assign pop_cmd      = q_r[rd_ptr_r];
  assign status.full  = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign status.empty = (count_r == '0);

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (QPTR_W+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && status.full))
    else $error("queue pushed while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && status.empty))
    else $error("queue popped while empty");

endmodule

>>> src/tmcw_front.sv
// front end: takes items, tracks the cursor and ring base, builds back-end commands
module tmcw_front
  import tmcw_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 80,
  parameter int SCREEN_HEIGHT = 25,
  parameter int TAB_STEP      = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_func,
  input  logic [7:0]       in_character,
  input  logic [7:0]       in_entry_color,
  input  logic [COL_W-1:0] in_column,
  input  logic [ROW_W-1:0] in_row,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [7:0]       cfg_text_color,
  input  back_status_t     back_status,
  input  queue_status_t    q_status,
  output logic             push,
  output cmd_t             push_cmd
);

  localparam logic [7:0]       W8       = 8'(SCREEN_WIDTH);
  localparam logic [5:0]       H6       = 6'(SCREEN_HEIGHT);
  localparam logic [7:0]       T8       = 8'(TAB_STEP);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(SCREEN_HEIGHT - 1);
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(SCREEN_WIDTH - 1);

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] base;
    logic             scr;
    logic [ROW_W-1:0] clr_row;
  } adv_t;

  logic [COL_W-1:0] cur_col_r;
  logic [ROW_W-1:0] cur_row_r;
  logic [ROW_W-1:0] base_r;
  logic [7:0]       text_color_r;

  logic [7:0]             c;
  logic [ROW_W-1:0]       r;
  logic [ROW_W-1:0]       b;
  logic [7:0]             ch;
  adv_t                   a1, a2;
  logic                   on_screen;
  logic [CELL_ADDR_W-1:0] idx_full;

  function automatic logic [CELL_ADDR_W-1:0] row_base(input logic [ROW_W-1:0] p);
    return CELL_ADDR_W'(p) * CELL_ADDR_W'(SCREEN_WIDTH);
  endfunction

  // logical row to physical row through the ring base, then to a cell address
  function automatic logic [CELL_ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] lr,
                                                       input logic [ROW_W-1:0] lb,
                                                       input logic [COL_W-1:0] lc);
    logic [5:0] s;
    logic [5:0] p;
    s = {1'b0, lr} + {1'b0, lb};
    p = (s >= H6) ? s - H6 : s;
    return row_base(p[ROW_W-1:0]) + CELL_ADDR_W'(lc);
  endfunction

  // next row; past the bottom the ring base moves and its old top row is cleared
  function automatic adv_t adv_row(input logic [ROW_W-1:0] lr, input logic [ROW_W-1:0] lb);
    adv_t       a;
    logic [5:0] nr;
    nr        = {1'b0, lr} + 6'd1;
    a.scr     = 1'b0;
    a.clr_row = lb;
    a.base    = lb;
    a.row     = nr[ROW_W-1:0];
    if (nr >= H6) begin
      a.scr  = 1'b1;
      a.row  = LAST_ROW;
      a.base = (lb == LAST_ROW) ? '0 : lb + ROW_W'(1);
    end
    return a;
  endfunction

  assign cfg_ready = 1'b1;
  assign in_stall  = q_status.full || back_status.init_busy;
  assign push      = in_valid && !in_stall;
  assign on_screen = ({1'b0, in_column} < W8) && ({1'b0, in_row} < H6);

  always_comb begin
    c        = {1'b0, cur_col_r};
    r        = cur_row_r;
    b        = base_r;
    ch       = in_character;
    a1       = '0;
    a2       = '0;
    push_cmd = '0;
    unique case (in_func)
      FUNC_PUT: begin
        if (in_character == CODE_NEWLINE) begin
          c                 = '0;
          a1                = adv_row(r, b);
          r                 = a1.row;
          b                 = a1.base;
          push_cmd.pre_clr  = a1.scr;
          push_cmd.pre_base = row_base(a1.clr_row);
        end else begin
          if (in_character == CODE_TAB) begin
            ch = CODE_SPACE;
            c  = c + T8;
            if (c >= W8) begin
              c                 = c - W8;
              a1                = adv_row(r, b);
              r                 = a1.row;
              b                 = a1.base;
              push_cmd.pre_clr  = a1.scr;
              push_cmd.pre_base = row_base(a1.clr_row);
            end
          end
          push_cmd.do_wr = 1'b1;
          push_cmd.addr  = cell_addr(r, b, c[COL_W-1:0]);
          push_cmd.wdata = {text_color_r, ch};
          c              = c + 8'd1;
          if (c >= W8) begin
            c                  = '0;
            a2                 = adv_row(r, b);
            r                  = a2.row;
            b                  = a2.base;
            push_cmd.post_clr  = a2.scr;
            push_cmd.post_base = row_base(a2.clr_row);
          end
        end
      end
      FUNC_WRITE: begin
        push_cmd.do_wr = on_screen;
        push_cmd.addr  = cell_addr(in_row, base_r, in_column);
        push_cmd.wdata = {in_entry_color, in_character};
      end
      FUNC_SET: begin
        c = ({1'b0, in_column} < W8) ? {1'b0, in_column} : {1'b0, LAST_COL};
        r = ({1'b0, in_row} < H6) ? in_row : LAST_ROW;
      end
      FUNC_READ: begin
        push_cmd.do_rd = on_screen;
        push_cmd.addr  = cell_addr(in_row, base_r, in_column);
      end
      default: ;
    endcase
    idx_full               = row_base(r) + CELL_ADDR_W'(c[COL_W-1:0]);
    push_cmd.cursor_index  = idx_full[IDX_W-1:0];
    push_cmd.cursor_column = c[COL_W-1:0];
    push_cmd.cursor_row    = r;
    push_cmd.scrolled      = a1.scr || a2.scr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_col_r    <= '0;
      cur_row_r    <= '0;
      base_r       <= '0;
      text_color_r <= RESET_COLOR;
    end else begin
      if (push) begin
        cur_col_r <= c[COL_W-1:0];
        cur_row_r <= r;
        base_r    <= b;
      end
      if (cfg_valid && cfg_ready) begin
        text_color_r <= cfg_text_color;
      end
    end
  end

endmodule

>>> src/tmcw_back.sv
// back end: cell store, reset fill, row clears, cell writes and reads, output register
module tmcw_back
  import tmcw_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 80,
  parameter int SCREEN_HEIGHT = 25
) (
  input  logic             clk,
  input  logic             rst_n,
  input  queue_status_t    q_status,
  output logic             pop,
  input  cmd_t             pop_cmd,
  output back_status_t     status,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [IDX_W-1:0] out_cursor_index,
  output logic [COL_W-1:0] out_cursor_column,
  output logic [ROW_W-1:0] out_cursor_row,
  output logic [15:0]      out_cell_data,
  output logic             out_scrolled
);

  localparam int CELLS  = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CLR_W  = $clog2(SCREEN_WIDTH);
  localparam logic [CLR_W-1:0]  CLR_LAST  = CLR_W'(SCREEN_WIDTH - 1);
  localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(CELLS - 1);

  typedef enum logic [5:0] {
    ST_INIT = 6'b000001,
    ST_IDLE = 6'b000010,
    ST_PRE  = 6'b000100,
    ST_OP   = 6'b001000,
    ST_POST = 6'b010000,
    ST_FIN  = 6'b100000
  } state_t;

  logic [CELL_W-1:0] cells_mem [CELLS];

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] init_cnt_r, init_cnt_nxt;
  logic [CLR_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [CELL_W-1:0] rdata_r;
  logic              out_valid_r, out_valid_nxt;
  logic              out_load;

  logic [IDX_W-1:0]  out_index_r;
  logic [COL_W-1:0]  out_column_r;
  logic [ROW_W-1:0]  out_row_r;
  logic [CELL_W-1:0] out_data_r;
  logic              out_scrolled_r;

  logic                   mem_we;
  logic [ADDR_W-1:0]      mem_waddr;
  logic [CELL_W-1:0]      mem_wdata;
  logic                   mem_re;
  logic [CELL_ADDR_W-1:0] clr_addr;

  assign status.init_busy  = (state_r == ST_INIT);
  assign out_valid         = out_valid_r;
  assign out_cursor_index  = out_index_r;
  assign out_cursor_column = out_column_r;
  assign out_cursor_row    = out_row_r;
  assign out_cell_data     = out_data_r;
  assign out_scrolled      = out_scrolled_r;

  // row sweep address for the clear before or after the cell access
  assign clr_addr = ((state_r == ST_PRE) ? cmd_r.pre_base : cmd_r.post_base)
                    + CELL_ADDR_W'(clr_cnt_r);

  always_comb begin
    state_nxt     = state_r;
    init_cnt_nxt  = init_cnt_r;
    clr_cnt_nxt   = clr_cnt_r;
    cmd_nxt       = cmd_r;
    pop           = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = cmd_r.addr[ADDR_W-1:0];
    mem_wdata     = cmd_r.wdata;
    mem_re        = 1'b0;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r) inside
      ST_INIT: begin
        mem_we       = 1'b1;
        mem_waddr    = init_cnt_r;
        mem_wdata    = RESET_CELL;
        init_cnt_nxt = init_cnt_r + ADDR_W'(1);
        if (init_cnt_r == CELL_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_status.empty) begin
          pop       = 1'b1;
          cmd_nxt   = pop_cmd;
          state_nxt = pop_cmd.pre_clr ? ST_PRE : ST_OP;
        end
      end
      ST_PRE, ST_POST: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_addr[ADDR_W-1:0];
        mem_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + CLR_W'(1);
        if (clr_cnt_r == CLR_LAST) begin
          clr_cnt_nxt = '0;
          state_nxt   = (state_r == ST_PRE) ? ST_OP : ST_FIN;
        end
      end
      ST_OP: begin
        mem_we    = cmd_r.do_wr;
        mem_re    = cmd_r.do_rd;
        state_nxt = cmd_r.post_clr ? ST_POST : ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      init_cnt_r  <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_cnt_r  <= init_cnt_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    if (out_load) begin
      out_index_r    <= cmd_r.cursor_index;
      out_column_r   <= cmd_r.cursor_column;
      out_row_r      <= cmd_r.cursor_row;
      out_data_r     <= cmd_r.do_rd ? rdata_r : '0;
      out_scrolled_r <= cmd_r.scrolled;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cells_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= cells_mem[cmd_r.addr[ADDR_W-1:0]];
    end
  end

  a_init_queue_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INIT) |-> q_status.empty)
    else $error("command queued during reset fill");

  a_waddr_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (int'(mem_waddr) < CELLS))
    else $error("cell write beyond the store");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (state_r == ST_IDLE) && !q_status.empty)
    else $error("command taken outside idle");

endmodule
